[rtl/sgbq_pkg.sv]
// Package for the grid binning table: payload types, grid sizing and divider constants.
package sgbq_pkg;

   // Grid and storage sizing.
   localparam int GRID_COLUMNS  = 64;
   localparam int GRID_ROWS     = 32;
   localparam int CELL_CAPACITY = 16;
   localparam int CELL_SPAN     = 50;
   localparam int ID_COUNT      = 8192;

   localparam int CELL_COUNT = GRID_COLUMNS * GRID_ROWS;
   localparam int CELL_AW    = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
   localparam int MEM_DEPTH  = CELL_COUNT * CELL_CAPACITY;
   localparam int MEM_AW     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int FILL_W     = $clog2(CELL_CAPACITY + 1);
   localparam int SLOT_W     = (CELL_CAPACITY > 1) ? $clog2(CELL_CAPACITY) : 1;
   localparam int COL_W      = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1;
   localparam int ROW_W      = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
   localparam int ID_W       = $clog2(ID_COUNT);

   // Field widths of the channels.
   localparam int CMD_W   = 2;
   localparam int COORD_W = 16;
   localparam int RAD_W   = 15;

   // Result limit register.
   localparam int LIMIT_W     = 7;
   localparam int MAX_RESULTS = 64;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(MAX_RESULTS);

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

   // Division by the cell span: a coordinate plus or minus the radius needs
   // OPD_W bits signed, and its magnitude MAG_W bits. The quotient is the
   // magnitude times a rounded-up reciprocal, shifted right by DIV_K. With
   // DIV_K chosen so that MAG_MAX * CELL_SPAN < 2**DIV_K the result is exact.
   localparam int OPD_W     = COORD_W + 2;
   localparam int MAG_W     = OPD_W - 1;
   localparam int DIV_K     = MAG_W + $clog2(CELL_SPAN);
   localparam int DIV_RECIP = ((2 ** DIV_K) + CELL_SPAN - 1) / CELL_SPAN;
   localparam int RECIP_W   = $clog2(DIV_RECIP + 1);
   localparam int PROD_W    = MAG_W + RECIP_W;
   localparam int QUO_W     = $clog2(((2 ** MAG_W) - 1) / CELL_SPAN + 1);
   localparam int GRID_MAX  = (GRID_COLUMNS > GRID_ROWS) ? GRID_COLUMNS : GRID_ROWS;
   localparam int GRID_W    = $clog2(GRID_MAX + 1);
   localparam int BND_W     = (QUO_W > GRID_W) ? QUO_W : GRID_W;

   // One input item.
   typedef struct packed {
      logic [CMD_W-1:0]          command;
      logic [ID_W-1:0]           entity_id;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic [RAD_W-1:0]          radius;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [ID_W-1:0] found_id;
      logic            id_valid;
      logic            accepted;
      logic            last;
   } rsp_type;

endpackage

[rtl/sgbq_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read port.
module sgbq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; read data holds while rd_en is low.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/spatial_grid_bin_query_top.sv]
// Uniform-grid binning table: clear, insert and neighbor query over two cell memories.
//
//   channel   ports                         direction   moves
//   req       req_valid/req_ready/req_data  in          one command per transfer
//   rsp       rsp_valid/rsp_ready/rsp_data  out         one result per transfer
//   csr       csr_wr_en/csr_wr_data         in          result limit, written at once
//
// One command is worked on at a time. Insert makes four passes of the shared span divider,
// then a fill read and a combined write. Query makes the same four passes, settles the
// result limit, reads the fill count of each cell visited, reads each id from the member
// memory and closes with a final result; clear sweeps zeros through the fill memory, one
// cell per cycle, then acknowledges.
// After reset the same sweep runs before the first command is taken.
// A stalled result channel holds the sequencer at its next result; req_ready is high
// only while the sequencer waits for a command.
module spatial_grid_bin_query_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  sgbq_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output sgbq_pkg::rsp_type               rsp_data,
   input  logic                            csr_wr_en,
   input  logic [sgbq_pkg::LIMIT_W-1:0]    csr_wr_data
);

   import sgbq_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_MUL,
      S_QUO,
      S_INS_RD,
      S_INS_WR,
      S_Q_START,
      S_Q_FILL_RD,
      S_Q_FILL,
      S_Q_EMIT,
      S_Q_END,
      S_RESP
   } state_type;

   // Registers and their next values.
   state_type            state_ff, state_in;
   logic [1:0]           step_ff, step_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic                 sign_ff, sign_in;
   logic [BND_W-1:0]     col_lo_ff, col_lo_in;
   logic [BND_W-1:0]     col_hi_ff, col_hi_in;
   logic [BND_W-1:0]     row_lo_ff, row_lo_in;
   logic [BND_W-1:0]     row_hi_ff, row_hi_in;
   logic                 empty_ff, empty_in;
   logic [CELL_AW-1:0]   clr_addr_ff, clr_addr_in;
   logic                 clr_resp_ff, clr_resp_in;
   req_type              item_ff, item_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [FILL_W-1:0]    fill_cnt_ff, fill_cnt_in;
   logic [LIMIT_W-1:0]   count_ff, count_in;
   logic [LIMIT_W-1:0]   lim_ff, lim_in;
   logic [LIMIT_W-1:0]   limit_ff, limit_in;
   logic                 held_valid_ff, held_valid_in;
   logic [ID_W-1:0]      held_id_ff, held_id_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   // Memory ports.
   logic                 fill_wr_en, fill_rd_en;
   logic [CELL_AW-1:0]   fill_wr_addr, fill_rd_addr;
   logic [FILL_W-1:0]    fill_wr_data, fill_rd_data;
   logic                 mem_wr_en, mem_rd_en;
   logic [MEM_AW-1:0]    mem_wr_addr, mem_rd_addr;
   logic [ID_W-1:0]      mem_wr_data, mem_rd_data;

   // Helpers.
   logic                 is_query;
   logic                 out_free;
   logic                 push;
   rsp_type              push_data;
   logic [OPD_W-1:0]     opd_base, opd_rad, opd;
   logic [OPD_W-1:0]     opd_neg;
   logic [MAG_W-1:0]     mag;
   logic [QUO_W-1:0]     quo;
   logic [BND_W-1:0]     lo_q, hi_q, edge_q;
   logic [CELL_AW-1:0]   cell_ins, cell_walk;
   logic                 walk_done;
   logic [ROW_W-1:0]     row_next;
   logic [COL_W-1:0]     col_next;
   logic [FILL_W-1:0]    slot_next;
   logic [LIMIT_W-1:0]   count_next;

   // Cell occupancy counts, one per cell.
   sgbq_ram #(
      .WIDTH (FILL_W),
      .DEPTH (CELL_COUNT)
   ) u_fill_ram (
      .clock   (clock),
      .wr_en   (fill_wr_en),
      .wr_addr (fill_wr_addr),
      .wr_data (fill_wr_data),
      .rd_en   (fill_rd_en),
      .rd_addr (fill_rd_addr),
      .rd_data (fill_rd_data)
   );

   // Stored ids, CELL_CAPACITY slots per cell.
   sgbq_ram #(
      .WIDTH (ID_W),
      .DEPTH (MEM_DEPTH)
   ) u_member_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign is_query = (item_ff.command == CMD_QUERY);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Divider operand: x or y, moved by the radius for a query (minus on even steps).
   always_comb begin
      opd_base = step_ff[1]
         ? {{(OPD_W-COORD_W){item_ff.pos_y[COORD_W-1]}}, item_ff.pos_y}
         : {{(OPD_W-COORD_W){item_ff.pos_x[COORD_W-1]}}, item_ff.pos_x};
      opd_rad  = is_query ? {{(OPD_W-RAD_W){1'b0}}, item_ff.radius} : '0;
      opd      = step_ff[0] ? (opd_base + opd_rad) : (opd_base - opd_rad);
      opd_neg  = ~opd + OPD_W'(1);
      mag      = opd[OPD_W-1] ? opd_neg[MAG_W-1:0] : opd[MAG_W-1:0];
   end

   // Quotient from the registered product, then clamping into the grid.
   always_comb begin
      quo    = QUO_W'(prod_ff >> DIV_K);
      lo_q   = sign_ff ? '0 : BND_W'(quo);
      edge_q = step_ff[1] ? BND_W'(GRID_ROWS - 1) : BND_W'(GRID_COLUMNS - 1);
      hi_q   = (lo_q > edge_q) ? edge_q : lo_q;
   end

   // Cell numbers for insert and for the query walk.
   assign cell_ins  = CELL_AW'(row_lo_ff * GRID_COLUMNS + col_lo_ff);
   assign cell_walk = CELL_AW'(row_ff * GRID_COLUMNS + col_ff);

   // Next cell of the walk: columns first within a row, then the next row.
   always_comb begin
      walk_done = (col_ff == col_hi_ff[COL_W-1:0]) && (row_ff == row_hi_ff[ROW_W-1:0]);
      if (col_ff == col_hi_ff[COL_W-1:0]) begin
         col_next = col_lo_ff[COL_W-1:0];
         row_next = row_ff + ROW_W'(1);
      end else begin
         col_next = col_ff + COL_W'(1);
         row_next = row_ff;
      end
      slot_next  = FILL_W'(slot_ff) + FILL_W'(1);
      count_next = count_ff + LIMIT_W'(1);
   end

   // Sequencer: next values of every register and the memory strobes.
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      prod_in       = prod_ff;
      sign_in       = sign_ff;
      col_lo_in     = col_lo_ff;
      col_hi_in     = col_hi_ff;
      row_lo_in     = row_lo_ff;
      row_hi_in     = row_hi_ff;
      empty_in      = empty_ff;
      clr_addr_in   = clr_addr_ff;
      clr_resp_in   = clr_resp_ff;
      item_in       = item_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      slot_in       = slot_ff;
      fill_cnt_in   = fill_cnt_ff;
      count_in      = count_ff;
      lim_in        = lim_ff;
      held_valid_in = held_valid_ff;
      held_id_in    = held_id_ff;
      limit_in      = csr_wr_en ? csr_wr_data : limit_ff;

      req_ready    = 1'b0;
      push         = 1'b0;
      push_data    = '0;
      fill_wr_en   = 1'b0;
      fill_wr_addr = clr_addr_ff;
      fill_wr_data = '0;
      fill_rd_en   = 1'b0;
      fill_rd_addr = cell_walk;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = MEM_AW'(cell_ins * CELL_CAPACITY + fill_rd_data[SLOT_W-1:0]);
      mem_wr_data  = item_ff.entity_id;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = MEM_AW'(cell_walk * CELL_CAPACITY + slot_ff);

      case (state_ff)
         // Sweep zeros through the fill memory, one cell per cycle.
         S_CLEAR: begin
            fill_wr_en = 1'b1;
            if (clr_addr_ff == CELL_AW'(CELL_COUNT - 1)) begin
               state_in = clr_resp_ff ? S_RESP : S_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + CELL_AW'(1);
            end
         end

         // Wait for a command.
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               item_in  = req_data;
               step_in  = '0;
               empty_in = 1'b0;
               case (req_data.command)
                  CMD_CLEAR: begin
                     clr_addr_in = '0;
                     clr_resp_in = 1'b1;
                     state_in    = S_CLEAR;
                  end
                  CMD_INSERT, CMD_QUERY: begin
                     state_in = S_MUL;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end

         // Multiply the operand magnitude by the span reciprocal.
         S_MUL: begin
            prod_in  = PROD_W'(mag) * PROD_W'(DIV_RECIP);
            sign_in  = opd[OPD_W-1];
            state_in = S_QUO;
         end

         // Clamp the quotient and file it as a low or high bound.
         S_QUO: begin
            case (step_ff)
               2'd0: col_lo_in = is_query ? lo_q : hi_q;
               2'd1: col_hi_in = hi_q;
               2'd2: row_lo_in = is_query ? lo_q : hi_q;
               default: row_hi_in = hi_q;
            endcase
            // A high bound below cell zero leaves nothing to search.
            if (step_ff[0] && sign_ff && (quo != '0)) begin
               empty_in = 1'b1;
            end
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               state_in = is_query ? S_Q_START : S_INS_RD;
            end else begin
               state_in = S_MUL;
            end
         end

         S_INS_RD: begin
            fill_rd_en   = 1'b1;
            fill_rd_addr = cell_ins;
            state_in     = S_INS_WR;
         end

         // Append the id if the cell has room, and report.
         S_INS_WR: begin
            if (out_free) begin
               push               = 1'b1;
               push_data.last     = 1'b1;
               if (fill_rd_data < FILL_W'(CELL_CAPACITY)) begin
                  push_data.accepted = 1'b1;
                  mem_wr_en          = 1'b1;
                  fill_wr_en         = 1'b1;
                  fill_wr_addr       = cell_ins;
                  fill_wr_data       = fill_rd_data + FILL_W'(1);
               end
               state_in = S_IDLE;
            end
         end

         // Settle the result limit and start the walk at the low corner.
         S_Q_START: begin
            count_in      = '0;
            held_valid_in = 1'b0;
            if (limit_ff == '0) begin
               lim_in = LIMIT_W'(1);
            end else if (limit_ff > LIMIT_W'(MAX_RESULTS)) begin
               lim_in = LIMIT_W'(MAX_RESULTS);
            end else begin
               lim_in = limit_ff;
            end
            if (empty_ff || (col_lo_ff > col_hi_ff) || (row_lo_ff > row_hi_ff)) begin
               state_in = S_Q_END;
            end else begin
               row_in   = row_lo_ff[ROW_W-1:0];
               col_in   = col_lo_ff[COL_W-1:0];
               state_in = S_Q_FILL_RD;
            end
         end

         S_Q_FILL_RD: begin
            fill_rd_en = 1'b1;
            state_in   = S_Q_FILL;
         end

         // Skip an empty cell, else read its first member.
         S_Q_FILL: begin
            fill_cnt_in = fill_rd_data;
            if (fill_rd_data == '0) begin
               if (walk_done) begin
                  state_in = S_Q_END;
               end else begin
                  row_in   = row_next;
                  col_in   = col_next;
                  state_in = S_Q_FILL_RD;
               end
            end else begin
               slot_in     = '0;
               mem_rd_en   = 1'b1;
               mem_rd_addr = MEM_AW'(cell_walk * CELL_CAPACITY);
               state_in    = S_Q_EMIT;
            end
         end

         // Take one id per cycle while the held id can leave; the previous id leaves once a later one exists.
         S_Q_EMIT: begin
            if (!held_valid_ff || out_free) begin
               if (held_valid_ff) begin
                  push               = 1'b1;
                  push_data.found_id = held_id_ff;
                  push_data.id_valid = 1'b1;
               end
               held_valid_in = 1'b1;
               held_id_in    = mem_rd_data;
               count_in      = count_next;
               if (count_next == lim_ff) begin
                  state_in = S_Q_END;
               end else if (slot_next < fill_cnt_ff) begin
                  slot_in     = slot_next[SLOT_W-1:0];
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = MEM_AW'(cell_walk * CELL_CAPACITY + slot_next);
               end else if (walk_done) begin
                  state_in = S_Q_END;
               end else begin
                  row_in   = row_next;
                  col_in   = col_next;
                  state_in = S_Q_FILL_RD;
               end
            end
         end

         // Final result of a query: the held id, or an empty marker.
         S_Q_END: begin
            if (out_free) begin
               push               = 1'b1;
               push_data.found_id = held_valid_ff ? held_id_ff : '0;
               push_data.id_valid = held_valid_ff;
               push_data.last     = 1'b1;
               held_valid_in      = 1'b0;
               state_in           = S_IDLE;
            end
         end

         // Single acknowledge for clear and unknown commands.
         S_RESP: begin
            if (out_free) begin
               push           = 1'b1;
               push_data.last = 1'b1;
               clr_resp_in    = 1'b0;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = push || (rsp_valid_ff && !rsp_ready);
      rsp_data_in  = push ? push_data : rsp_data_ff;
   end

   // State, datapath and output registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         step_ff       <= '0;
         clr_addr_ff   <= '0;
         clr_resp_ff   <= 1'b0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         limit_ff      <= LIMIT_RESET;
         empty_ff      <= 1'b0;
         count_ff      <= '0;
         lim_ff        <= LIMIT_RESET;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         clr_addr_ff   <= clr_addr_in;
         clr_resp_ff   <= clr_resp_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         limit_ff      <= limit_in;
         empty_ff      <= empty_in;
         count_ff      <= count_in;
         lim_ff        <= lim_in;
      end
      prod_ff     <= prod_in;
      sign_ff     <= sign_in;
      col_lo_ff   <= col_lo_in;
      col_hi_ff   <= col_hi_in;
      row_lo_ff   <= row_lo_in;
      row_hi_ff   <= row_hi_in;
      item_ff     <= item_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      slot_ff     <= slot_in;
      fill_cnt_ff <= fill_cnt_in;
      held_id_ff  <= held_id_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A cell count written back never exceeds the cell capacity.
   a_fill_cap: assert property (@(posedge clock) disable iff (reset)
      fill_wr_en |-> (fill_wr_data <= FILL_W'(CELL_CAPACITY)))
      else $error("cell count written above capacity");

   // The walk only visits cells inside the clamped query window.
   a_walk_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_Q_FILL_RD) |->
         (BND_W'(col_ff) >= col_lo_ff && BND_W'(col_ff) <= col_hi_ff &&
          BND_W'(row_ff) >= row_lo_ff && BND_W'(row_ff) <= row_hi_ff))
      else $error("query walk left its window");

   // The id count of a query never passes the settled limit.
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_Q_EMIT || state_ff == S_Q_END) |-> (count_ff <= lim_ff))
      else $error("query returned more ids than its limit");

   // A command transfer is followed by a busy cycle.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second command taken while busy");

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the grid binning table: predicts every result and compares.
module tb_top;
   import sgbq_pkg::*;

   localparam int WATCHDOG_CYCLES = 40000;
   localparam int DRAIN_CYCLES    = 50;
   localparam int PHASE_ITEMS     = 56;
   localparam int MAX_REPORTS     = 100;

   // The block answers a command code it does not know with a single empty result.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // Patterns the result side uses to hold off transfers.
   typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE} ready_mode_e;

   // Keeps a private copy of the grid and the queue of results that the block still owes.
   class bin_table_checker;
      int unsigned     cell_fill [CELL_COUNT];
      logic [ID_W-1:0] cell_ids [MEM_DEPTH];
      int unsigned     result_limit;
      rsp_type         pending [$];
      int              errors;

      function new();
         foreach (cell_fill[i]) cell_fill[i] = 0;
         result_limit = int'(LIMIT_RESET);
         errors = 0;
      endfunction

      function void set_limit(logic [LIMIT_W-1:0] value);
         result_limit = int'(value);
      endfunction

      function int clamp_cell(int value, int count);
         if (value < 0) return 0;
         if (value >= count) return count - 1;
         return value;
      endfunction

      // Works out the results of one accepted command and updates the grid copy.
      function void note_command(req_type item);
         int x, y, r, cell_idx, col_lo, col_hi, row_lo, row_hi, cap, total, n;
         rsp_type res;
         x = int'(item.pos_x);
         y = int'(item.pos_y);
         r = int'(item.radius);
         res = '0;
         res.last = 1'b1;
         case (item.command)
            CMD_CLEAR: begin
               foreach (cell_fill[i]) cell_fill[i] = 0;
               pending.push_back(res);
            end
            CMD_INSERT: begin
               cell_idx = clamp_cell(x / CELL_SPAN, GRID_COLUMNS)
                        + clamp_cell(y / CELL_SPAN, GRID_ROWS) * GRID_COLUMNS;
               if (cell_fill[cell_idx] < CELL_CAPACITY) begin
                  cell_ids[cell_idx * CELL_CAPACITY + cell_fill[cell_idx]] = item.entity_id;
                  cell_fill[cell_idx]++;
                  res.accepted = 1'b1;
               end
               pending.push_back(res);
            end
            CMD_QUERY: begin
               cap = result_limit;
               if (cap < 1) cap = 1;
               if (cap > MAX_RESULTS) cap = MAX_RESULTS;
               // Low bounds are only raised to zero, high bounds only lowered to the edge.
               col_lo = (x - r) / CELL_SPAN;
               col_hi = (x + r) / CELL_SPAN;
               row_lo = (y - r) / CELL_SPAN;
               row_hi = (y + r) / CELL_SPAN;
               if (col_lo < 0) col_lo = 0;
               if (col_hi >= GRID_COLUMNS) col_hi = GRID_COLUMNS - 1;
               if (row_lo < 0) row_lo = 0;
               if (row_hi >= GRID_ROWS) row_hi = GRID_ROWS - 1;
               // Count the ids in range first so that the final one can carry last.
               total = 0;
               for (int row = row_lo; row <= row_hi; row++)
                  for (int col = col_lo; col <= col_hi; col++)
                     total += cell_fill[row * GRID_COLUMNS + col];
               if (total > cap) total = cap;
               if (total == 0) pending.push_back(res);
               n = 0;
               for (int row = row_lo; row <= row_hi && n < total; row++) begin
                  for (int col = col_lo; col <= col_hi && n < total; col++) begin
                     cell_idx = row * GRID_COLUMNS + col;
                     for (int i = 0; i < cell_fill[cell_idx] && n < total; i++) begin
                        res = '0;
                        res.found_id = cell_ids[cell_idx * CELL_CAPACITY + i];
                        res.id_valid = 1'b1;
                        res.last = (n == total - 1);
                        pending.push_back(res);
                        n++;
                     end
                  end
               end
            end
            default: begin
               pending.push_back(res);
            end
         endcase
      endfunction

      function void compare_field(string name, logic [ID_W-1:0] want, logic [ID_W-1:0] seen);
         if (seen !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
         end
      endfunction

      // Checks one result transfer against the oldest expectation.
      function void check_result(rsp_type seen);
         rsp_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: result with none expected, actual id %0d valid %0b acc %0b last %0b",
                        $time, seen.found_id, seen.id_valid, seen.accepted, seen.last);
            return;
         end
         want = pending.pop_front();
         compare_field("found_id", want.found_id, seen.found_id);
         compare_field("id_valid", want.id_valid, seen.id_valid);
         compare_field("accepted", want.accepted, seen.accepted);
         compare_field("last", want.last, seen.last);
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   req_type            req_data = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   rsp_type            rsp_data;
   logic               csr_wr_en = 1'b0;
   logic [LIMIT_W-1:0] csr_wr_data = '0;
   int                 idle_cycles = 0;
   bin_table_checker   board;

   spatial_grid_bin_query_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Every result transfer is checked at the edge that completes it.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_data);
   end

   // Ends the run when no transfer has happened on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_CYCLES) begin
         $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
         $display("spatial_grid_bin_query_top regression: fail");
         $finish;
      end
   end

   // The result side switches between always ready, coin flips and sparse ready pulses.
   initial begin : rsp_stall_pattern
      ready_mode_e mode;
      int span, step;
      step = 0;
      forever begin
         mode = ready_mode_e'($urandom_range(0, 2));
         span = $urandom_range(10, 120);
         repeat (span) begin
            @(posedge clock);
            step++;
            case (mode)
               READY_ALWAYS: rsp_ready <= 1'b1;
               READY_COIN:   rsp_ready <= ($urandom_range(0, 1) == 1);
               default:      rsp_ready <= (step % 6 == 0);
            endcase
         end
      end
   end

   function automatic req_type make_command(logic [CMD_W-1:0] cmd, int id, int x, int y, int r);
      req_type item;
      item.command   = cmd;
      item.entity_id = ID_W'(id);
      item.pos_x     = COORD_W'(x);
      item.pos_y     = COORD_W'(y);
      item.radius    = RAD_W'(r);
      return item;
   endfunction

   // Mostly lands in a small hot area so that cells fill up; the rest spreads wide.
   function automatic int pick_coord(int hot_cell, int hot_span, int extent);
      int roll;
      logic signed [COORD_W-1:0] raw;
      roll = $urandom_range(0, 99);
      raw = COORD_W'($urandom());
      if (roll < 55) return hot_cell * CELL_SPAN + int'($urandom_range(0, hot_span * CELL_SPAN - 1));
      if (roll < 80) return int'($urandom_range(0, extent * CELL_SPAN - 1));
      if (roll < 90) return int'($urandom_range(0, extent * CELL_SPAN + 400)) - 200;
      return int'(raw);
   endfunction

   function automatic int pick_radius();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return $urandom_range(0, 60);
      if (roll < 75) return $urandom_range(0, 400);
      if (roll < 90) return $urandom_range(0, 3000);
      return $urandom_range(0, 32767);
   endfunction

   // Holds one command on the request channel until its transfer completes.
   task automatic send_command(input req_type item);
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_command(item);
   endtask

   task automatic send_random_command(int hot_col, int hot_row, int hot_span, int insert_pct);
      int roll;
      logic [CMD_W-1:0] cmd;
      roll = $urandom_range(0, 99);
      if (roll < 1) cmd = CMD_CLEAR;
      else if (roll < 5) cmd = CMD_UNUSED;
      else if (roll < 5 + insert_pct) cmd = CMD_INSERT;
      else cmd = CMD_QUERY;
      send_command(make_command(cmd, $urandom_range(0, ID_COUNT - 1),
                                pick_coord(hot_col, hot_span, GRID_COLUMNS),
                                pick_coord(hot_row, hot_span, GRID_ROWS),
                                pick_radius()));
   endtask

   task automatic wait_until_drained();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(logic [LIMIT_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      board.set_limit(value);
      csr_wr_en   <= 1'b0;
   endtask

   // One phase: wait for the block to go idle, set the limit, then send bursts with gaps.
   task automatic run_phase(logic [LIMIT_W-1:0] limit_value, int hot_span, int insert_pct);
      int hot_col, hot_row, left, burst, gap;
      wait_until_drained();
      write_limit(limit_value);
      hot_col = $urandom_range(0, GRID_COLUMNS - 1);
      hot_row = $urandom_range(0, GRID_ROWS - 1);
      left = PHASE_ITEMS;
      while (left > 0) begin
         burst = $urandom_range(1, 12);
         if (burst > left) burst = left;
         repeat (burst) send_random_command(hot_col, hot_row, hot_span, insert_pct);
         left -= burst;
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if ($urandom_range(0, 29) == 0) begin
            req_valid <= 1'b0;
            wait_until_drained();
         end else if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
   endtask

   initial begin : stimulus
      board = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed commands, sent back to back.
      send_command(make_command(CMD_QUERY, 0, 1600, 800, 100));
      send_command(make_command(CMD_UNUSED, ID_COUNT - 1, -1, -1, 32767));
      send_command(make_command(CMD_INSERT, 0, -32768, -32768, 0));
      send_command(make_command(CMD_INSERT, ID_COUNT - 1, 32767, 32767, 32767));
      send_command(make_command(CMD_INSERT, 'h0AAA, 49, 49, 0));
      // Truncation toward zero keeps small negative coordinates in the first cell.
      send_command(make_command(CMD_INSERT, 'h1555, -49, -1, 0));
      send_command(make_command(CMD_INSERT, 'h0123, CELL_SPAN, 0, 0));
      send_command(make_command(CMD_INSERT, 77, GRID_COLUMNS * CELL_SPAN - 1,
                                GRID_ROWS * CELL_SPAN - 1, 0));
      send_command(make_command(CMD_QUERY, 0, 0, 0, 0));
      send_command(make_command(CMD_QUERY, 0, 25, 25, 25));
      send_command(make_command(CMD_QUERY, 0, 32767, 32767, 32767));
      send_command(make_command(CMD_QUERY, 0, -32768, -32768, 32767));
      // Ranges that come out empty once only the far bounds are clamped, and one over the whole grid.
      send_command(make_command(CMD_QUERY, 0, 32767, 100, 0));
      send_command(make_command(CMD_QUERY, 0, -32768, 0, 0));
      send_command(make_command(CMD_QUERY, 0, GRID_COLUMNS * CELL_SPAN - 1,
                                GRID_ROWS * CELL_SPAN - 1, 32767));
      send_command(make_command(CMD_CLEAR, ID_COUNT - 1, -1, -1, 32767));
      send_command(make_command(CMD_QUERY, 0, 0, 0, 32767));
      send_command(make_command(CMD_UNUSED, 0, 0, 0, 0));
      req_valid <= 1'b0;

      // Random phases over the limit settings, the extremes among them.
      run_phase({LIMIT_W{1'b1}}, 1, 70);
      run_phase('0, 2, 50);
      run_phase(LIMIT_W'(1), 2, 50);
      run_phase(LIMIT_W'(MAX_RESULTS), 1, 45);
      run_phase(LIMIT_W'($urandom_range(2, MAX_RESULTS - 1)), 2, 50);
      run_phase(LIMIT_W'($urandom_range(0, 127)), 2, 55);

      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("spatial_grid_bin_query_top regression: pass");
      end else begin
         $display("spatial_grid_bin_query_top regression: fail");
      end
      $finish;
   end

endmodule

[files.f]
rtl/sgbq_pkg.sv
rtl/sgbq_ram.sv
rtl/spatial_grid_bin_query_top.sv
tb/sv/tb_top.sv
